// File: design/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros
// shared clocked checks, sampled on clk and held off while rst is high
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every edge out of reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// expression never true out of reset
`define ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error(msg);

`endif

// File: design/rit_pkg.sv
// ---------------------------------------------------------------------------
// rit_pkg
// types and constants for the tactile region intensity tracker
// ---------------------------------------------------------------------------
package rit_pkg;

  localparam int NUM_REGIONS = 14;
  localparam int SLOT_W      = 4;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int INC_W       = 9;
  localparam int PRESS_SHIFT = 15;

  localparam logic [7:0]  DECAY_STEP    = 8'd5;
  localparam logic [8:0]  BUMP_BASE     = 9'd10;
  localparam logic [7:0]  INTENSITY_MAX = 8'd255;
  localparam logic [9:0]  MIN_TAXELS    = 10'd3;
  localparam logic [11:0] PRESS_RECIP   = 12'd3277;

  // command codes
  localparam logic [1:0] CMD_DECAY   = 2'd0;
  localparam logic [1:0] CMD_CONTACT = 2'd1;
  localparam logic [1:0] CMD_READ    = 2'd2;
  localparam logic [1:0] CMD_UNUSED  = 2'd3;

  // body parts
  localparam logic [2:0] BP_NONE        = 3'd0;
  localparam logic [2:0] BP_LEFT_HAND   = 3'd1;
  localparam logic [2:0] BP_LEFT_FORE   = 3'd2;
  localparam logic [2:0] BP_LEFT_UPPER  = 3'd3;
  localparam logic [2:0] BP_RIGHT_HAND  = 3'd4;
  localparam logic [2:0] BP_RIGHT_FORE  = 3'd5;
  localparam logic [2:0] BP_RIGHT_UPPER = 3'd6;
  localparam logic [2:0] BP_TORSO       = 3'd7;

  // regions
  localparam logic [3:0] RG_NONE      = 4'd0;
  localparam logic [3:0] RG_T_UP_POS  = 4'd1;
  localparam logic [3:0] RG_T_UP_NEG  = 4'd2;
  localparam logic [3:0] RG_T_LO_POS  = 4'd3;
  localparam logic [3:0] RG_T_LO_NEG  = 4'd4;
  localparam logic [3:0] RG_RU_POS    = 4'd5;
  localparam logic [3:0] RG_RU_NEG    = 4'd6;
  localparam logic [3:0] RG_RF_NEG    = 4'd7;
  localparam logic [3:0] RG_RF_POS    = 4'd8;
  localparam logic [3:0] RG_RH        = 4'd9;
  localparam logic [3:0] RG_LU_POS    = 4'd10;
  localparam logic [3:0] RG_LU_NEG    = 4'd11;
  localparam logic [3:0] RG_LF_NEG    = 4'd12;
  localparam logic [3:0] RG_LF_POS    = 4'd13;
  localparam logic [3:0] RG_LH        = 4'd14;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT_EN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_EN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TORSO_EN = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPLIT_Y  = 2'd3;

  typedef enum logic [1:0] {
    OP_DECAY,
    OP_CONTACT,
    OP_READ,
    OP_NONE
  } op_kind_t;

  typedef struct packed {
    op_kind_t          kind;
    logic [3:0]        region;
    logic [SLOT_W-1:0] slot;
    logic              slot_valid;
    logic              bump;
    logic [INC_W-1:0]  inc;
    logic              report_en;
  } work_t;

endpackage

// File: design/rit_front.sv
// ---------------------------------------------------------------------------
// rit_front
// holds the configuration, takes input beats and classifies them into work
// ---------------------------------------------------------------------------
module rit_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [rit_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rit_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      command,
  input  logic [2:0]                      body_part,
  input  logic [9:0]                      taxel_count,
  input  logic signed [15:0]              pos_x,
  input  logic signed [15:0]              pos_y,
  input  logic signed [15:0]              pos_z,
  input  logic [11:0]                     pressure,
  input  logic [3:0]                      read_region,
  output logic                            push_valid,
  input  logic                            push_ready,
  output rit_pkg::work_t                  push_data
);
  import rit_pkg::*;

  logic               left_enable;
  logic               right_enable;
  logic               torso_enable;
  logic signed [15:0] torso_split_y;

  logic [23:0]      prod;
  logic [INC_W-1:0] inc;
  logic [3:0]       region_cls;
  logic             group_en;
  logic             z_pos;
  logic             x_pos;
  logic             upper;
  work_t            w;

  always_ff @(posedge clk) begin
    if (rst) begin
      left_enable   <= 1'b1;
      right_enable  <= 1'b1;
      torso_enable  <= 1'b1;
      torso_split_y <= -16'sd328;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LEFT_EN:  left_enable   <= cfg_data[0];
        CFG_RIGHT_EN: right_enable  <= cfg_data[0];
        CFG_TORSO_EN: torso_enable  <= cfg_data[0];
        CFG_SPLIT_Y:  torso_split_y <= $signed(cfg_data);
        default:      ;
      endcase
    end
  end

  // pressure / 10 by reciprocal, exact over the 12-bit range
  assign prod = {12'd0, pressure} * {12'd0, PRESS_RECIP};
  assign inc  = BUMP_BASE + prod[PRESS_SHIFT +: INC_W];

  assign z_pos = !pos_z[15];
  assign x_pos = !pos_x[15] && (pos_x != 16'sd0);
  assign upper = (pos_y >= torso_split_y);

  always_comb begin
    region_cls = RG_NONE;
    group_en   = 1'b0;
    unique case (body_part)
      BP_TORSO: begin
        region_cls = upper ? (z_pos ? RG_T_UP_POS : RG_T_UP_NEG)
                           : (z_pos ? RG_T_LO_POS : RG_T_LO_NEG);
        group_en   = torso_enable;
      end
      BP_RIGHT_UPPER: begin
        region_cls = z_pos ? RG_RU_POS : RG_RU_NEG;
        group_en   = right_enable;
      end
      BP_RIGHT_FORE: begin
        region_cls = x_pos ? RG_RF_POS : RG_RF_NEG;
        group_en   = right_enable;
      end
      BP_RIGHT_HAND: begin
        region_cls = RG_RH;
        group_en   = right_enable;
      end
      BP_LEFT_UPPER: begin
        region_cls = z_pos ? RG_LU_POS : RG_LU_NEG;
        group_en   = left_enable;
      end
      BP_LEFT_FORE: begin
        region_cls = x_pos ? RG_LF_POS : RG_LF_NEG;
        group_en   = left_enable;
      end
      BP_LEFT_HAND: begin
        region_cls = RG_LH;
        group_en   = left_enable;
      end
      BP_NONE: begin
        region_cls = RG_NONE;
        group_en   = 1'b0;
      end
      default: begin
        region_cls = RG_NONE;
        group_en   = 1'b0;
      end
    endcase
  end

  always_comb begin
    w      = '0;
    w.kind = OP_NONE;
    unique case (command)
      CMD_DECAY: w.kind = OP_DECAY;
      CMD_CONTACT: begin
        w.kind       = OP_CONTACT;
        w.region     = region_cls;
        w.slot       = region_cls - 4'd1;
        w.slot_valid = (region_cls != RG_NONE);
        w.bump       = (taxel_count > MIN_TAXELS);
        w.inc        = inc;
        w.report_en  = group_en;
      end
      CMD_READ: begin
        w.kind       = OP_READ;
        w.slot       = read_region - 4'd1;
        w.slot_valid = (read_region != 4'd0) && (read_region <= 4'(NUM_REGIONS));
      end
      CMD_UNUSED: w.kind = OP_NONE;
      default:    w.kind = OP_NONE;
    endcase
  end

  assign in_ready   = push_ready;
  assign push_valid = in_valid;
  assign push_data  = w;

endmodule

// File: design/rit_queue.sv
// ---------------------------------------------------------------------------
// rit_queue
// short first-in first-out buffer of classified work between front and back
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module rit_queue #(
  parameter int DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  rit_pkg::work_t push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output rit_pkg::work_t pop_data
);
  import rit_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  work_t            entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `ASSERT_NEVER(a_count_bound, count > CNT_W'(DEPTH), "queue fill beyond depth")
  `ASSERT_CLK(a_count_up, push && !pop |=> count == CNT_W'($past(count) + 1'b1), "fill lost")

endmodule

// File: design/rit_back.sv
// ---------------------------------------------------------------------------
// rit_back
// carries out queued work on the region intensities and registers the result
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module rit_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           pop_valid,
  output logic           pop_ready,
  input  rit_pkg::work_t pop_data,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [3:0]     region,
  output logic           report,
  output logic [7:0]     intensity
);
  import rit_pkg::*;

  logic [7:0] level [NUM_REGIONS];
  logic [7:0] cur;
  logic [9:0] sum;
  logic [7:0] bumped;
  logic       pop;
  logic [3:0] res_region;
  logic       res_report;
  logic [7:0] res_intensity;

  assign pop_ready = !out_valid || out_ready;
  assign pop       = pop_valid && pop_ready;

  assign cur    = pop_data.slot_valid ? level[pop_data.slot] : 8'd0;
  assign sum    = {2'b00, cur} + {1'b0, pop_data.inc};
  assign bumped = (sum > {2'b00, INTENSITY_MAX}) ? INTENSITY_MAX : sum[7:0];

  always_comb begin
    res_region    = RG_NONE;
    res_report    = 1'b0;
    res_intensity = 8'd0;
    unique case (pop_data.kind)
      OP_CONTACT: begin
        res_region = pop_data.region;
        if (pop_data.slot_valid) begin
          if (pop_data.bump) begin
            res_intensity = bumped;
            res_report    = pop_data.report_en;
          end else begin
            res_intensity = cur;
          end
        end
      end
      OP_READ:  res_intensity = cur;
      OP_DECAY: res_intensity = 8'd0;
      OP_NONE:  res_intensity = 8'd0;
      default:  res_intensity = 8'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      for (int i = 0; i < NUM_REGIONS; i++) begin
        level[i] <= 8'd0;
      end
    end else begin
      if (pop) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (pop && pop_data.kind == OP_DECAY) begin
        for (int i = 0; i < NUM_REGIONS; i++) begin
          level[i] <= (level[i] > DECAY_STEP) ? level[i] - DECAY_STEP : 8'd0;
        end
      end else if (pop && pop_data.kind == OP_CONTACT && pop_data.slot_valid
                   && pop_data.bump) begin
        level[pop_data.slot] <= bumped;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      region    <= res_region;
      report    <= res_report;
      intensity <= res_intensity;
    end
  end

  `ASSERT_NEVER(a_no_pop_on_stall, out_valid && !out_ready && pop, "beat overwritten")
  `ASSERT_CLK(a_report_region, out_valid && report |-> region != RG_NONE, "report without region")
  `ASSERT_CLK(a_decay_down, pop && pop_data.kind == OP_DECAY |=> level[0] <= $past(level[0]), "decay rose")

endmodule

// File: design/tactile_region_intensity_tracker.sv
// ---------------------------------------------------------------------------
// tactile_region_intensity_tracker
// classifies skin contacts into 14 regions and tracks a decaying intensity
// ---------------------------------------------------------------------------
//  channel | handshake          | payload
//  --------+--------------------+--------------------------------------------
//  in      | in_valid/in_ready  | command body_part taxel_count pos_x pos_y
//          |                    | pos_z pressure read_region
//  out     | out_valid/out_ready| region report intensity
//  cfg     | cfg_we             | cfg_index cfg_data
//
//  one beat per cycle sustained while out_ready is high; an input beat passes
//  through the work queue register and then the result register
//  rst empties the queue, drops the result valid, clears the intensities
//  and loads the config reset values
//  a stalled output fills the queue, then in_ready drops
// ---------------------------------------------------------------------------
module tactile_region_intensity_tracker #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [rit_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rit_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      command,
  input  logic [2:0]                      body_part,
  input  logic [9:0]                      taxel_count,
  input  logic signed [15:0]              pos_x,
  input  logic signed [15:0]              pos_y,
  input  logic signed [15:0]              pos_z,
  input  logic [11:0]                     pressure,
  input  logic [3:0]                      read_region,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [3:0]                      region,
  output logic                            report,
  output logic [7:0]                      intensity
);
  import rit_pkg::*;

  logic  push_valid;
  logic  push_ready;
  work_t push_data;
  logic  pop_valid;
  logic  pop_ready;
  work_t pop_data;

  rit_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .command     (command),
    .body_part   (body_part),
    .taxel_count (taxel_count),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .pos_z       (pos_z),
    .pressure    (pressure),
    .read_region (read_region),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_data   (push_data)
  );

  rit_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  rit_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .region    (region),
    .report    (report),
    .intensity (intensity)
  );

endmodule

// File: dv/region_intensity_checker.sv
// ---------------------------------------------------------------------------
// region_intensity_checker
// watches the tracker's channels, predicts every result beat and compares
// keeps its own copy of the region intensities and of the config registers;
// each accepted input beat queues one predicted result, each accepted
// output beat is compared field by field with the oldest one
// ---------------------------------------------------------------------------
module region_intensity_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [rit_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rit_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic [1:0]                      command,
  input  logic [2:0]                      body_part,
  input  logic [9:0]                      taxel_count,
  input  logic signed [15:0]              pos_x,
  input  logic signed [15:0]              pos_y,
  input  logic signed [15:0]              pos_z,
  input  logic [11:0]                     pressure,
  input  logic [3:0]                      read_region,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic [3:0]                      region,
  input  logic                            report,
  input  logic [7:0]                      intensity,
  output int                              fail_count,
  output int                              pending,
  output int                              checked,
  output int                              reported
);
  import rit_pkg::*;

  localparam logic signed [15:0] SPLIT_Y_RESET = -16'sd328;
  localparam logic [11:0]        PRESS_DIV     = 12'd10;

  typedef struct packed {
    logic [3:0] region;
    logic       report;
    logic [7:0] intensity;
  } tracker_out_t;

  logic [7:0]         level [1:NUM_REGIONS];
  logic               left_en;
  logic               right_en;
  logic               torso_en;
  logic signed [15:0] split_y;
  tracker_out_t       outs_due [$];

  task automatic note_mismatch(string what, int got, int due);
    $display("%0t mismatch on %s: got %0d, expected %0d", $time, what, got, due);
    fail_count++;
  endtask

  function automatic logic [3:0] region_of(logic [2:0] part, logic signed [15:0] x,
                                           logic signed [15:0] y, logic signed [15:0] z);
    logic z_pos;
    logic x_pos;
    logic upper;
    z_pos = (z >= 0);
    x_pos = (x > 0);
    upper = (y >= split_y);
    case (part)
      BP_TORSO: begin
        if (upper) region_of = z_pos ? RG_T_UP_POS : RG_T_UP_NEG;
        else       region_of = z_pos ? RG_T_LO_POS : RG_T_LO_NEG;
      end
      BP_RIGHT_UPPER: region_of = z_pos ? RG_RU_POS : RG_RU_NEG;
      BP_RIGHT_FORE:  region_of = x_pos ? RG_RF_POS : RG_RF_NEG;
      BP_RIGHT_HAND:  region_of = RG_RH;
      BP_LEFT_UPPER:  region_of = z_pos ? RG_LU_POS : RG_LU_NEG;
      BP_LEFT_FORE:   region_of = x_pos ? RG_LF_POS : RG_LF_NEG;
      BP_LEFT_HAND:   region_of = RG_LH;
      default:        region_of = RG_NONE;
    endcase
  endfunction

  function automatic logic group_on(logic [3:0] rg);
    if (rg >= RG_LU_POS && rg <= RG_LH)          group_on = left_en;
    else if (rg >= RG_RU_POS && rg <= RG_RH)     group_on = right_en;
    else if (rg >= RG_T_UP_POS && rg <= RG_T_LO_NEG) group_on = torso_en;
    else                                         group_on = 1'b0;
  endfunction

  // applies one command to the intensities and returns its result
  function automatic tracker_out_t apply_command(logic [1:0] cmd, logic [2:0] part,
                                                 logic [9:0] taxels,
                                                 logic signed [15:0] x,
                                                 logic signed [15:0] y,
                                                 logic signed [15:0] z,
                                                 logic [11:0] press, logic [3:0] rd);
    tracker_out_t r;
    logic [3:0]   rg;
    logic [9:0]   sum;
    int           i;
    r = '0;
    case (cmd)
      CMD_DECAY: begin
        for (i = 1; i <= NUM_REGIONS; i++)
          level[i] = (level[i] > DECAY_STEP) ? level[i] - DECAY_STEP : 8'd0;
      end
      CMD_CONTACT: begin
        rg = region_of(part, x, y, z);
        r.region = rg;
        if (rg != RG_NONE) begin
          if (taxels > MIN_TAXELS) begin
            sum = 10'(level[rg] + BUMP_BASE + press / PRESS_DIV);
            level[rg] = (sum > INTENSITY_MAX) ? INTENSITY_MAX : sum[7:0];
            r.report = group_on(rg);
          end
          r.intensity = level[rg];
        end
      end
      CMD_READ: begin
        if (rd >= 1 && rd <= NUM_REGIONS) r.intensity = level[rd];
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    tracker_out_t due;
    int           i;
    if (rst) begin
      for (i = 1; i <= NUM_REGIONS; i++) level[i] = 8'd0;
      left_en  = 1'b1;
      right_en = 1'b1;
      torso_en = 1'b1;
      split_y  = SPLIT_Y_RESET;
      outs_due.delete();
      fail_count = 0;
      checked    = 0;
      reported   = 0;
      pending   <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_LEFT_EN:  left_en  = cfg_data[0];
          CFG_RIGHT_EN: right_en = cfg_data[0];
          CFG_TORSO_EN: torso_en = cfg_data[0];
          CFG_SPLIT_Y:  split_y  = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        checked++;
        if (outs_due.size() == 0) begin
          note_mismatch("result beat with nothing due, region", int'(region), 0);
        end else begin
          due = outs_due.pop_front();
          if (region !== due.region)
            note_mismatch("region", int'(region), int'(due.region));
          if (report !== due.report)
            note_mismatch("report", int'(report), int'(due.report));
          if (intensity !== due.intensity)
            note_mismatch("intensity", int'(intensity), int'(due.intensity));
          if (due.report) reported++;
        end
      end
      if (in_valid && in_ready)
        outs_due.push_back(apply_command(command, body_part, taxel_count, pos_x, pos_y,
                                         pos_z, pressure, read_region));
      pending <= outs_due.size();
    end
  end

endmodule

// File: dv/tactile_region_intensity_tracker_tb.sv
// ---------------------------------------------------------------------------
// tactile_region_intensity_tracker_tb
// stimulus and verdict for the tactile region intensity tracker
// a directed pass over every body part, region boundary, command and
// saturation case is followed by random beats under several register
// settings, with random gaps and stalls on both channels, one long output
// hold-off and a drain in the middle of one phase; the checker predicts and compares
// ---------------------------------------------------------------------------
module tactile_region_intensity_tracker_tb;
  import rit_pkg::*;

  localparam int                 PHASES        = 8;
  localparam int                 PHASE_BEATS   = 250;
  localparam int                 HOLD_CYCLES   = 200;
  localparam logic signed [15:0] SPLIT_Y_RESET = -16'sd328;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   in_valid;
  logic                   in_ready;
  logic [1:0]             command;
  logic [2:0]             body_part;
  logic [9:0]             taxel_count;
  logic signed [15:0]     pos_x;
  logic signed [15:0]     pos_y;
  logic signed [15:0]     pos_z;
  logic [11:0]            pressure;
  logic [3:0]             read_region;
  logic                   out_valid;
  logic                   out_ready;
  logic [3:0]             region;
  logic                   report;
  logic [7:0]             intensity;

  int                     fail_count;
  int                     pending;
  int                     checked;
  int                     reported;
  int                     sent;
  int                     settings;
  bit                     tx_idle_on;
  bit                     rx_idle_on;
  bit                     rx_hold_req;
  logic signed [15:0]     split_y_now;

  always #5 clk = ~clk;

  tactile_region_intensity_tracker dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .command(command), .body_part(body_part), .taxel_count(taxel_count),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .pressure(pressure), .read_region(read_region),
    .out_valid(out_valid), .out_ready(out_ready),
    .region(region), .report(report), .intensity(intensity)
  );

  region_intensity_checker tracker_check (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .command(command), .body_part(body_part), .taxel_count(taxel_count),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .pressure(pressure), .read_region(read_region),
    .out_valid(out_valid), .out_ready(out_ready),
    .region(region), .report(report), .intensity(intensity),
    .fail_count(fail_count), .pending(pending),
    .checked(checked), .reported(reported)
  );

  task automatic send_beat(logic [1:0] cmd, logic [2:0] part, logic [9:0] taxels,
                           logic signed [15:0] x, logic signed [15:0] y,
                           logic signed [15:0] z, logic [11:0] press, logic [3:0] rd);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    command     <= cmd;
    body_part   <= part;
    taxel_count <= taxels;
    pos_x       <= x;
    pos_y       <= y;
    pos_z       <= z;
    pressure    <= press;
    read_region <= rd;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  task automatic touch(logic [2:0] part, logic [9:0] taxels, logic signed [15:0] x,
                       logic signed [15:0] y, logic signed [15:0] z, logic [11:0] press);
    send_beat(CMD_CONTACT, part, taxels, x, y, z, press, 4'd0);
  endtask

  task automatic ask(logic [3:0] rd);
    send_beat(CMD_READ, BP_NONE, 10'd0, 16'sd0, 16'sd0, 16'sd0, 12'd0, rd);
  endtask

  // stop offering and wait until every result beat is back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic set_tracker(logic left, logic right, logic torso, logic signed [15:0] split);
    logic [CFG_IDX_W-1:0]  idx  [4];
    logic [CFG_DATA_W-1:0] data [4];
    logic [31:0]           rnd;
    int                    i;
    drain();
    rnd = $urandom;
    idx[0] = CFG_LEFT_EN;  data[0] = {rnd[15:1], left};
    idx[1] = CFG_RIGHT_EN; data[1] = {rnd[31:17], right};
    idx[2] = CFG_TORSO_EN; data[2] = {rnd[16:2], torso};
    idx[3] = CFG_SPLIT_Y;  data[3] = split;
    cfg_we <= 1'b1;
    for (i = 0; i < 4; i++) begin
      cfg_index <= idx[i];
      cfg_data  <= data[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    split_y_now = split;
    settings++;
  endtask

  function automatic logic signed [15:0] pick_coord();
    int p;
    p = $urandom_range(0, 9);
    if (p < 3) return 16'($urandom_range(0, 2) - 1);
    if (p == 3) return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
    return 16'($urandom);
  endfunction

  task automatic random_beat();
    int                 pick;
    logic [1:0]         cmd;
    logic [9:0]         taxels;
    logic signed [15:0] y;
    logic [11:0]        press;
    pick = $urandom_range(0, 99);
    if (pick < 55)      cmd = CMD_CONTACT;
    else if (pick < 78) cmd = CMD_DECAY;
    else if (pick < 95) cmd = CMD_READ;
    else                cmd = CMD_UNUSED;
    pick = $urandom_range(0, 99);
    if (pick < 15)      taxels = 10'($urandom_range(0, 3));
    else if (pick < 80) taxels = 10'($urandom_range(4, 40));
    else                taxels = 10'($urandom);
    y = pick_coord();
    if ($urandom_range(0, 9) < 3) y = 16'(split_y_now + $urandom_range(0, 2) - 1);
    press = ($urandom_range(0, 9) < 7) ? 12'($urandom_range(0, 99)) : 12'($urandom);
    send_beat(cmd, 3'($urandom_range(0, 7)), taxels, pick_coord(), y, pick_coord(), press,
              4'($urandom_range(0, 15)));
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int stall;
    out_ready = 1'b0;
    repeat (4) @(posedge clk);
    forever begin
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      stall = rx_idle_on ? $urandom_range(0, 5) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin
    int ph;
    int n;
    rst         = 1'b1;
    cfg_we      = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    in_valid    = 1'b0;
    command     = CMD_DECAY;
    body_part   = BP_NONE;
    taxel_count = '0;
    pos_x       = '0;
    pos_y       = '0;
    pos_z       = '0;
    pressure    = '0;
    read_region = '0;
    tx_idle_on  = 1'b1;
    rx_idle_on  = 1'b1;
    rx_hold_req = 1'b0;
    split_y_now = SPLIT_Y_RESET;
    sent        = 0;
    settings    = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed pass under reset settings
    ask(4'd1);
    ask(4'd0);
    ask(4'd15);
    touch(BP_TORSO, 10'd4, 16'sd0, SPLIT_Y_RESET, 16'sd0, 12'd0);
    touch(BP_TORSO, 10'd4, 16'sd0, SPLIT_Y_RESET - 16'sd1, -16'sd1, 12'd4095);
    touch(BP_TORSO, 10'd5, 16'sd0, 16'sh7fff, 16'sh8000, 12'd9);
    touch(BP_TORSO, 10'd5, 16'sd0, 16'sh8000, 16'sh7fff, 12'd10);
    touch(BP_RIGHT_UPPER, 10'd4, 16'sd0, 16'sd0, 16'sd0, 12'd100);
    touch(BP_RIGHT_UPPER, 10'd4, 16'sd0, 16'sd0, -16'sd1, 12'd100);
    touch(BP_RIGHT_FORE, 10'd4, 16'sd0, 16'sd0, 16'sd0, 12'd55);
    touch(BP_RIGHT_FORE, 10'd4, 16'sd1, 16'sd0, 16'sd0, 12'd55);
    touch(BP_RIGHT_HAND, 10'd4, 16'sd0, 16'sd0, 16'sd0, 12'd19);
    touch(BP_LEFT_UPPER, 10'd4, 16'sd0, 16'sd0, 16'sh7fff, 12'd200);
    touch(BP_LEFT_UPPER, 10'd4, 16'sd0, 16'sd0, 16'sh8000, 12'd200);
    touch(BP_LEFT_FORE, 10'd4, 16'sh8000, 16'sd0, 16'sd0, 12'd1);
    touch(BP_LEFT_FORE, 10'd4, 16'sh7fff, 16'sd0, 16'sd0, 12'd1);
    touch(BP_LEFT_HAND, 10'd1023, 16'sd0, 16'sd0, 16'sd0, 12'd4095);
    touch(BP_NONE, 10'd1023, 16'sd0, 16'sd0, 16'sd0, 12'd4095);
    touch(BP_TORSO, 10'd3, 16'sd0, SPLIT_Y_RESET, 16'sd0, 12'd4095);
    touch(BP_RIGHT_HAND, 10'd0, 16'sd0, 16'sd0, 16'sd0, 12'd0);
    send_beat(CMD_DECAY, BP_NONE, 10'd0, 16'sd0, 16'sd0, 16'sd0, 12'd0, 4'd0);
    ask(4'd14);
    send_beat(CMD_DECAY, BP_NONE, 10'd0, 16'sd0, 16'sd0, 16'sd0, 12'd0, 4'd0);
    send_beat(CMD_UNUSED, BP_TORSO, 10'd1023, 16'sd0, 16'sd0, 16'sd0, 12'd4095, 4'd1);
    ask(4'd4);

    // random phases under changing settings
    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       set_tracker(1'b0, 1'b0, 1'b0, 16'sh8000);
        1:       set_tracker(1'b1, 1'b1, 1'b1, 16'sh7fff);
        2:       set_tracker(1'b1, 1'b0, 1'b1, 16'sd0);
        3:       set_tracker(1'b0, 1'b1, 1'b0, SPLIT_Y_RESET);
        default: set_tracker(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                             1'($urandom_range(0, 1)), pick_coord());
      endcase
      tx_idle_on = (ph % 3) != 0;
      rx_idle_on = (ph % 4) != 3;
      if (ph == 2) rx_hold_req = 1'b1;
      for (n = 0; n < PHASE_BEATS; n++) begin
        random_beat();
        if (ph == 4 && n == PHASE_BEATS / 2) drain();
      end
    end

    drain();
    repeat (5) @(posedge clk);
    $display("sent %0d input beats over %0d register settings, reset settings included",
             sent, settings + 1);
    $display("compared %0d result beats, %0d of them reported contacts", checked, reported);
    if (fail_count == 0 && pending == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #3000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// File: sim.f
+incdir+design
design/rit_pkg.sv
design/rit_front.sv
design/rit_queue.sv
design/rit_back.sv
design/tactile_region_intensity_tracker.sv
dv/region_intensity_checker.sv
dv/tactile_region_intensity_tracker_tb.sv
